### src/pwlm_pkg.sv
`default_nettype none

package pwlm_pkg;

	// request kinds
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_MAP  = 1'b1;

	// Q16.16 limits
	localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	// quotient is below 2^40 once the overflow test passes; two bits per step
	localparam int QUOT_W   = 40;
	localparam int DIV_STEPS = QUOT_W / 2;
	localparam int DIV_CW   = $clog2(DIV_STEPS);

	// result source select
	typedef logic [2:0] res_sel_t;
	localparam res_sel_t RES_PASS = 3'd0;
	localparam res_sel_t RES_Y0   = 3'd1;
	localparam res_sel_t RES_ZERO = 3'd2;
	localparam res_sel_t RES_OVF  = 3'd3;
	localparam res_sel_t RES_FIN  = 3'd4;

	typedef struct packed {
		logic              req_type;
		logic [3:0]        entry_index;
		logic signed [31:0] entry_x;
		logic signed [31:0] entry_y;
		logic signed [31:0] in_value;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] mapped_value;
		logic              passed_through;
		logic              zero_step;
		logic              saturated;
	} res_item_t;

	typedef struct packed {
		logic     we;
		logic     cap_in;
		logic     cap_last;
		logic     shift_prev;
		logic     seg_load;
		logic     seg_last;
		logic     diff_load;
		logic     mul_load;
		logic     div_init;
		logic     div_step;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic desc;
		logic hit;
		logic zstep;
		logic ovf;
	} dp_status_t;

endpackage

`default_nettype wire

### src/pwlm_ctrl.sv
`default_nettype none

module pwlm_ctrl #(
	parameter int TABLE_ENTRIES = 16,
	parameter int AW = $clog2(TABLE_ENTRIES)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	input  wire logic                  req_type,
	output logic                       req_ready,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	input  wire pwlm_pkg::dp_status_t  status,
	output pwlm_pkg::dp_cmd_t          cmd,
	output logic [AW-1:0]              rd_addr
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PRIME = 4'd1;
	localparam logic [3:0] S_SRCH  = 4'd2;
	localparam logic [3:0] S_DIFF  = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_OVF   = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_FIN   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
	localparam logic [AW-1:0] SRCH_END = AW'(TABLE_ENTRIES - 2);

	logic [3:0]                  state_q, state_d;
	logic [AW-1:0]               cnt_q, cnt_d;
	logic [pwlm_pkg::DIV_CW-1:0] step_q, step_d;
	logic                        res_valid_q;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		step_d    = step_q;
		cmd       = '0;
		req_ready = 1'b0;
		rd_addr   = cnt_q;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				rd_addr   = LAST_IDX;
				if (req_valid) begin
					if (req_type == pwlm_pkg::REQ_MAP) begin
						cmd.cap_in = 1'b1;
						state_d    = S_PRIME;
					end else begin
						cmd.we = 1'b1;
					end
				end
			end
			S_PRIME: begin
				cmd.cap_last = 1'b1;
				rd_addr      = '0;
				cnt_d        = '0;
				state_d      = S_SRCH;
			end
			S_SRCH: begin
				rd_addr        = cnt_q + AW'(1);
				cmd.shift_prev = 1'b1;
				if (cnt_q == '0 && status.desc) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = pwlm_pkg::RES_PASS;
					state_d      = S_DONE;
				end else if (cnt_q == '0 && status.hit) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = pwlm_pkg::RES_Y0;
					state_d      = S_DONE;
				end else if (status.hit) begin
					cmd.seg_load = 1'b1;
					state_d      = S_DIFF;
				end else if (cnt_q == SRCH_END) begin
					cmd.seg_load = 1'b1;
					cmd.seg_last = 1'b1;
					state_d      = S_DIFF;
				end else begin
					cnt_d = cnt_q + AW'(1);
				end
			end
			S_DIFF: begin
				cmd.diff_load = 1'b1;
				if (status.zstep) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = pwlm_pkg::RES_ZERO;
					state_d      = S_DONE;
				end else begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = S_OVF;
			end
			S_OVF: begin
				if (status.ovf) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = pwlm_pkg::RES_OVF;
					state_d      = S_DONE;
				end else begin
					cmd.div_init = 1'b1;
					step_d       = '0;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == pwlm_pkg::DIV_CW'(pwlm_pkg::DIV_STEPS - 1)) begin
					state_d = S_FIN;
				end else begin
					step_d = step_q + pwlm_pkg::DIV_CW'(1);
				end
			end
			S_FIN: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = pwlm_pkg::RES_FIN;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!res_valid_q || res_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			step_q  <= step_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

### src/pwlm_dp.sv
`default_nettype none

module pwlm_dp #(
	parameter int TABLE_ENTRIES = 16,
	parameter int AW = $clog2(TABLE_ENTRIES)
) (
	input  wire logic                 clk,
	input  wire pwlm_pkg::req_item_t  req_data,
	input  wire pwlm_pkg::dp_cmd_t    cmd,
	input  wire logic [AW-1:0]        rd_addr,
	output pwlm_pkg::dp_status_t      status,
	output pwlm_pkg::res_item_t       res_data
);

	localparam int IW = (AW > 4) ? AW : 4;
	localparam int QW = pwlm_pkg::QUOT_W;

	// table: {x, y} per entry
	logic [63:0] mem_q [TABLE_ENTRIES];
	logic [63:0] rd_q;

	logic [IW-1:0] idx_w;
	logic          idx_ok;

	logic signed [31:0] v_q, last_x_q, last_y_q, prev_x_q, prev_y_q;
	logic signed [31:0] xi_q, xp_q, yi_q, yp_q;
	logic signed [31:0] rd_x, rd_y;

	logic [31:0]        md_q, my_q, ms_q;
	logic               fneg_q;
	logic signed [31:0] ybase_q;
	logic [63:0]        prod_q;
	logic [31:0]        rem_q;
	logic [QW-1:0]      wq_q;

	pwlm_pkg::res_item_t res_q, out_q, res_d;

	// differences and magnitudes
	logic signed [32:0] dv, dy, dx;
	logic [32:0]        adv, ady, adx;

	// two restoring steps per cycle
	logic [32:0] t1, t2, r1, r2;
	logic        ge1, ge2;

	// final correction
	logic signed [41:0] ysum, qext, fsum;
	logic               fsat;

	assign idx_w  = IW'(req_data.entry_index);
	assign idx_ok = int'(req_data.entry_index) < TABLE_ENTRIES;

	assign rd_x = signed'(rd_q[63:32]);
	assign rd_y = signed'(rd_q[31:0]);

	always_ff @(posedge clk) begin
		if (cmd.we && idx_ok) begin
			mem_q[idx_w[AW-1:0]] <= {req_data.entry_x, req_data.entry_y};
		end
		rd_q <= mem_q[rd_addr];
	end

	always_comb begin
		dv  = 33'(xi_q) - 33'(v_q);
		dy  = 33'(yi_q) - 33'(yp_q);
		dx  = 33'(xi_q) - 33'(xp_q);
		adv = dv[32] ? 33'(-dv) : 33'(dv);
		ady = dy[32] ? 33'(-dy) : 33'(dy);
		adx = dx[32] ? 33'(-dx) : 33'(dx);
	end

	always_comb begin
		t1  = {rem_q, wq_q[QW-1]};
		ge1 = t1 >= {1'b0, ms_q};
		r1  = ge1 ? (t1 - {1'b0, ms_q}) : t1;
		t2  = {r1[31:0], wq_q[QW-2]};
		ge2 = t2 >= {1'b0, ms_q};
		r2  = ge2 ? (t2 - {1'b0, ms_q}) : t2;
	end

	always_comb begin
		ysum = 42'(ybase_q);
		qext = signed'({2'b00, wq_q});
		fsum = fneg_q ? (ysum + qext) : (ysum - qext);
		fsat = !((&fsum[41:31]) || !(|fsum[41:31]));
	end

	// next result word for the selected source
	always_comb begin
		res_d = '0;
		case (cmd.res_sel)
			pwlm_pkg::RES_PASS: begin
				res_d.mapped_value   = v_q;
				res_d.passed_through = 1'b1;
			end
			pwlm_pkg::RES_Y0: begin
				res_d.mapped_value = rd_y;
			end
			pwlm_pkg::RES_ZERO: begin
				res_d.mapped_value = yi_q;
				res_d.zero_step    = 1'b1;
			end
			pwlm_pkg::RES_OVF: begin
				res_d.mapped_value = fneg_q ? pwlm_pkg::Q_MAX : pwlm_pkg::Q_MIN;
				res_d.saturated    = 1'b1;
			end
			pwlm_pkg::RES_FIN: begin
				if (fsat) begin
					res_d.mapped_value = fsum[41] ? pwlm_pkg::Q_MIN : pwlm_pkg::Q_MAX;
				end else begin
					res_d.mapped_value = fsum[31:0];
				end
				res_d.saturated = fsat;
			end
			default: begin
				res_d.mapped_value = v_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			v_q <= req_data.in_value;
		end
		if (cmd.cap_last) begin
			last_x_q <= rd_x;
			last_y_q <= rd_y;
		end
		if (cmd.shift_prev) begin
			prev_x_q <= rd_x;
			prev_y_q <= rd_y;
		end
		if (cmd.seg_load) begin
			if (cmd.seg_last) begin
				// no breakpoint above: run along the last segment
				xi_q <= last_x_q;
				yi_q <= last_y_q;
				xp_q <= rd_x;
				yp_q <= rd_y;
			end else begin
				xi_q <= rd_x;
				yi_q <= rd_y;
				xp_q <= prev_x_q;
				yp_q <= prev_y_q;
			end
		end
		if (cmd.diff_load) begin
			md_q    <= adv[31:0];
			my_q    <= ady[31:0];
			ms_q    <= adx[31:0];
			fneg_q  <= (dv[32] != dy[32]) != dx[32];
			ybase_q <= yi_q;
		end
		if (cmd.mul_load) begin
			prod_q <= 64'(md_q) * 64'(my_q);
		end
		if (cmd.div_init) begin
			rem_q <= 32'(prod_q[63:QW]);
			wq_q  <= prod_q[QW-1:0];
		end else if (cmd.div_step) begin
			rem_q <= r2[31:0];
			wq_q  <= {wq_q[QW-3:0], ge1, ge2};
		end
		if (cmd.res_load) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	always_comb begin
		status.desc  = last_x_q < rd_x;
		status.hit   = v_q < rd_x;
		status.zstep = xi_q == xp_q;
		status.ovf   = 32'(prod_q[63:QW]) >= ms_q;
	end

	assign res_data = out_q;

endmodule

`default_nettype wire

### src/piecewise_linear_table_map.sv
// Piecewise-linear table map, Q16.16 signed. A load request (req_type 0) writes
// breakpoint (entry_x, entry_y) at entry_index and gives no result;
// indexes at or above TABLE_ENTRIES are dropped. A map request (req_type 1)
// searches the table for the first breakpoint above in_value, then
// interpolates on that segment (extrapolating along the last segment past the
// end), returns the first y below the first breakpoint, passes the input
// through when the last x lies below the first x, and returns the upper y with
// zero_step set when the segment has zero width. Results saturate to the
// 32-bit range. The search reads one table entry per cycle from a
// single-read-port memory, then a multiply and a restoring divider (two
// quotient bits per cycle) form the segment fraction. Pass-through and
// first-y cases finish in the search, zero-width and overflow cases before
// the divider. One request is worked at a time; a new request is taken while
// the previous result waits in the output register. Entries must be loaded
// before a map request reads them.
`default_nettype none

module piecewise_linear_table_map #(
	parameter int TABLE_ENTRIES = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire pwlm_pkg::req_item_t req_data,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output pwlm_pkg::res_item_t      res_data
);

	localparam int AW = $clog2(TABLE_ENTRIES);

	// command bundle from sequencer, compare results back from datapath
	pwlm_pkg::dp_cmd_t    cmd;
	pwlm_pkg::dp_status_t status;
	logic [AW-1:0]        rd_addr;

	pwlm_ctrl #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW(AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_type (req_data.req_type),
		.req_ready(req_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.status   (status),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	pwlm_dp #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.AW(AW)
	) u_dp (
		.clk     (clk),
		.req_data(req_data),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.status  (status),
		.res_data(res_data)
	);

endmodule

`default_nettype wire

### src/pwlm_checker.sv
`default_nettype none

module pwlm_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_ready,
	input wire pwlm_pkg::req_item_t req_data,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire pwlm_pkg::res_item_t res_data
);

	// a waiting result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed or dropped while stalled");

	// a map request keeps the block busy on the next cycle
	a_map_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_data.req_type == pwlm_pkg::REQ_MAP |=> !req_ready)
		else $error("request taken during a map");

	// a new result only shows up while a map is in progress
	a_res_from_map: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!req_ready))
		else $error("result without a map request");

	// flags are exclusive
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.zero_step && res_data.saturated) &&
			!(res_data.passed_through && (res_data.zero_step || res_data.saturated)))
		else $error("conflicting result flags");

endmodule

bind piecewise_linear_table_map pwlm_checker u_pwlm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req_data (req_data),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res_data (res_data)
);

`default_nettype wire
